>>> sv/lbc_pkg.sv
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types and constants for the card number Luhn and brand checker.
// ----------------------------------------------------------------------------
`default_nettype none

package lbc_pkg;

  // input width and decimal layout
  localparam int NumBits   = 63;
  localparam int NumDigits = 19;
  localparam int BcdW      = 4 * NumDigits;

  localparam int BitCntW   = 6;
  localparam int DigCntW   = 5;

  localparam logic [BitCntW-1:0] BitLast = BitCntW'(NumBits - 1);
  localparam logic [DigCntW-1:0] DigLast = DigCntW'(NumDigits - 1);

  // digit counts that carry a brand
  localparam logic [DigCntW-1:0] Len13 = 5'd13;
  localparam logic [DigCntW-1:0] Len15 = 5'd15;
  localparam logic [DigCntW-1:0] Len16 = 5'd16;

  // verdict codes
  typedef enum logic [1:0] {
    VERDICT_INVALID   = 2'd0,
    VERDICT_LEN15_3X  = 2'd1,
    VERDICT_LEN16_5X  = 2'd2,
    VERDICT_LEAD4     = 2'd3
  } verdict_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // control from sequencer to the datapath units
  typedef struct packed {
    logic load;    // take a new word, clear accumulators
    logic dabble;  // one binary-to-bcd shift step
    logic scan;    // consume the lowest bcd digit
  } lbc_ctrl_t;

endpackage

`default_nettype wire

>>> sv/lbc_bcd.sv
// ----------------------------------------------------------------------------
// lbc_bcd
// Shift-add-3 binary to bcd converter, one input bit per cycle, then a
// digit shifter that hands out one decimal digit per cycle, lowest first.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_bcd
  import lbc_pkg::*;
(
  input  logic               clk_i,
  input  lbc_ctrl_t          ctrl_i,
  input  logic [NumBits-1:0] number_i,
  output logic [3:0]         digit_o
);

  logic [NumBits-1:0] bin_q, bin_d;
  logic [BcdW-1:0]    bcd_q, bcd_d;
  logic [BcdW-1:0]    bcd_adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int g = 0; g < NumDigits; g++) begin
      if (bcd_q[4*g +: 4] >= 4'd5) begin
        bcd_adj[4*g +: 4] = bcd_q[4*g +: 4] + 4'd3;
      end else begin
        bcd_adj[4*g +: 4] = bcd_q[4*g +: 4];
      end
    end
  end

  // next value of the shift registers
  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    if (ctrl_i.load) begin
      bin_d = number_i;
      bcd_d = '0;
    end else if (ctrl_i.dabble) begin
      bcd_d = {bcd_adj[BcdW-2:0], bin_q[NumBits-1]};
      bin_d = {bin_q[NumBits-2:0], 1'b0};
    end else if (ctrl_i.scan) begin
      bcd_d = {4'd0, bcd_q[BcdW-1:4]};
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign digit_o = bcd_q[3:0];

endmodule

`default_nettype wire

>>> sv/lbc_scan.sv
// ----------------------------------------------------------------------------
// lbc_scan
// Digit accumulator: Luhn sum mod 10, digit count and the two leading
// digits, one decimal digit per cycle; decodes the verdict at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_scan
  import lbc_pkg::*;
(
  input  logic               clk_i,
  input  lbc_ctrl_t          ctrl_i,
  input  logic [3:0]         digit_i,
  input  logic [DigCntW-1:0] idx_i,
  output verdict_e           verdict_o
);

  logic [3:0]         sum_q, sum_d;
  logic [DigCntW-1:0] count_q, count_d;
  logic [3:0]         hi_q, hi_d;
  logic [3:0]         lo_q, lo_d;
  logic [3:0]         prev_q, prev_d;

  logic [4:0]         dbl;
  logic [3:0]         term;
  logic [4:0]         sum_raw;

  // doubled digit on odd places, folded back below 10
  always_comb begin
    dbl = {digit_i, 1'b0};
    if (idx_i[0]) begin
      if (dbl > 5'd9) begin
        term = 4'(dbl - 5'd9);
      end else begin
        term = dbl[3:0];
      end
    end else begin
      term = digit_i;
    end
    sum_raw = {1'b0, sum_q} + {1'b0, term};
  end

  // accumulator update
  always_comb begin
    sum_d   = sum_q;
    count_d = count_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    prev_d  = prev_q;
    if (ctrl_i.load) begin
      sum_d   = '0;
      count_d = '0;
      hi_d    = '0;
      lo_d    = '0;
      prev_d  = '0;
    end else if (ctrl_i.scan) begin
      if (sum_raw >= 5'd10) begin
        sum_d = 4'(sum_raw - 5'd10);
      end else begin
        sum_d = sum_raw[3:0];
      end
      if (digit_i != 4'd0) begin
        count_d = idx_i + DigCntW'(1);
        hi_d    = digit_i;
        lo_d    = prev_q;
      end
      prev_d = digit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q   <= sum_d;
    count_q <= count_d;
    hi_q    <= hi_d;
    lo_q    <= lo_d;
    prev_q  <= prev_d;
  end

  // brand decode from length and leading digits
  always_comb begin
    verdict_o = VERDICT_INVALID;
    if (sum_q == 4'd0) begin
      if (count_q == Len15) begin
        if (hi_q == 4'd3 && (lo_q == 4'd4 || lo_q == 4'd7)) begin
          verdict_o = VERDICT_LEN15_3X;
        end
      end else if (count_q == Len13) begin
        if (hi_q == 4'd4) begin
          verdict_o = VERDICT_LEAD4;
        end
      end else if (count_q == Len16) begin
        if (hi_q == 4'd5 && lo_q >= 4'd1 && lo_q <= 4'd5) begin
          verdict_o = VERDICT_LEN16_5X;
        end else if (hi_q == 4'd4) begin
          verdict_o = VERDICT_LEAD4;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/card_number_luhn_brand_check.sv
// ----------------------------------------------------------------------------
// card_number_luhn_brand_check
// Card number check by Luhn mod-10 and brand prefix.
// ----------------------------------------------------------------------------
// A word runs from acceptance through the shift-add-3 converter (one input bit
// per cycle), then the digit accumulator (one decimal digit per cycle), and
// last the write of the result register. The word is loaded at the accepting
// edge itself. The input stalls for the whole of that time and opens again
// once the result is in the output register, so the block takes no new word
// before it is through with the last one. A new word can be taken while the
// previous verdict still waits downstream; the finish step then holds until
// the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module card_number_luhn_brand_check
  import lbc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [NumBits-1:0] card_number_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         verdict_o
);

  state_e             state_q, state_d;
  logic [BitCntW-1:0] bit_cnt_q, bit_cnt_d;
  logic [DigCntW-1:0] dig_cnt_q, dig_cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [1:0]         verdict_q, verdict_d;

  lbc_ctrl_t          ctrl;
  logic [3:0]         digit;
  verdict_e           verdict_res;
  logic               in_take;
  logic               out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_take    = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // datapath units
  lbc_bcd u_bcd (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .number_i (card_number_i),
    .digit_o  (digit)
  );

  lbc_scan u_scan (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .digit_i   (digit),
    .idx_i     (dig_cnt_q),
    .verdict_o (verdict_res)
  );

  // sequencer next state and outputs
  always_comb begin
    state_d     = state_q;
    bit_cnt_d   = bit_cnt_q;
    dig_cnt_d   = dig_cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    verdict_d   = verdict_q;
    ctrl        = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          ctrl.load = 1'b1;
          bit_cnt_d = '0;
          state_d   = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        ctrl.dabble = 1'b1;
        bit_cnt_d   = bit_cnt_q + BitCntW'(1);
        if (bit_cnt_q == BitLast) begin
          dig_cnt_d = '0;
          state_d   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctrl.scan = 1'b1;
        dig_cnt_d = dig_cnt_q + DigCntW'(1);
        if (dig_cnt_q == DigLast) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          verdict_d   = verdict_res;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // counters and result payload
  always_ff @(posedge clk_i) begin
    bit_cnt_q <= bit_cnt_d;
    dig_cnt_q <= dig_cnt_d;
    verdict_q <= verdict_d;
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

`ifndef ASSERT_OFF
  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FINISH)
    else $error("result word appeared outside the finish step");

  a_convert_full_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && $past(state_q) == ST_CONVERT) |-> $past(bit_cnt_q) == BitLast)
    else $error("conversion left before all input bits were shifted");

  a_scan_full_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && $past(state_q) == ST_SCAN) |-> $past(dig_cnt_q) == DigLast)
    else $error("digit scan left before all digits were consumed");

  a_finish_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && out_valid_q && out_stall_i) |=> state_q == ST_FINISH)
    else $error("verdict dropped while output register was full");
`endif

endmodule

`default_nettype wire
